[rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// shared widths, types and constants for the 3x3 matrix inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;

  localparam int EW = ELEM_WIDTH;
  localparam int PW = 2 * EW;           // element product
  localparam int CW = PW + 1;           // cofactor
  localparam int DW = 3 * EW + 3;       // determinant
  localparam int NSH = 2 * FRAC_BITS + 1;
  localparam int NW = ((CW + NSH > DW) ? (CW + NSH) : DW) + 1;  // dividend
  localparam int QB = EW;               // quotient bits kept
  localparam int FRONT_LAT = 5;
  localparam int LANE_LAT  = QB + 1;
  localparam int DATA_W = ((9 * EW + 7) / 8) * 8;

  typedef logic signed [EW-1:0] elem_t;
  typedef logic signed [CW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  typedef struct packed {
    logic          neg;
    logic          big;
    logic [QB-1:0] q;
  } quo_t;

  localparam logic ONE_OVF = (FRAC_BITS >= EW - 1);
  localparam elem_t ONE_VAL = ONE_OVF ? elem_t'({1'b0, {(EW-1){1'b1}}})
                                      : elem_t'(64'(1) << FRAC_BITS);

endpackage

[rtl/m3i_cofactor.sv]
// ----------------------------------------------------------------------------
// m3i_cofactor
// cofactor products, adjugate and determinant pipeline
// ----------------------------------------------------------------------------
module m3i_cofactor import m3i_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  elem_t a [9],
  output cof_t  c [9],
  output det_t  det
);

  logic signed [PW-1:0] p1 [9];
  logic signed [PW-1:0] p2 [9];
  elem_t a1 [3];
  elem_t a2 [3];
  cof_t  c2 [9];
  cof_t  c3 [9];
  cof_t  c4 [9];
  logic signed [PW:0] lo [3];
  logic signed [PW:0] hi [3];
  det_t t [3];

  // index pairs of each cofactor: x*y - u*v
  localparam int IX [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IY [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IU [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IV [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  localparam int DC [3] = '{0, 3, 6};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        p1[k] <= a[IX[k]] * a[IY[k]];
        p2[k] <= a[IU[k]] * a[IV[k]];
        c2[k] <= CW'(p1[k]) - CW'(p2[k]);
        c3[k] <= c2[k];
        c4[k] <= c3[k];
        c[k]  <= c4[k];
      end
      for (int k = 0; k < 3; k++) begin
        a1[k] <= a[k];
        a2[k] <= a1[k];
        lo[k] <= a2[k] * $signed({1'b0, c2[DC[k]][EW-1:0]});
        hi[k] <= a2[k] * $signed(c2[DC[k]][CW-1:EW]);
        t[k]  <= DW'(lo[k]) + (DW'(hi[k]) <<< EW);
      end
      det <= t[0] + t[1] + t[2];
    end
  end

endmodule

[rtl/m3i_div_lane.sv]
// ----------------------------------------------------------------------------
// m3i_div_lane
// one rounded restoring divider lane, one quotient bit per stage
// ----------------------------------------------------------------------------
module m3i_div_lane import m3i_pkg::*; (
  input  logic clk,
  input  logic en,
  input  cof_t c,
  input  det_t det,
  output quo_t quo
);

  logic [CW-1:0] cm;
  logic [DW-1:0] dm;
  logic [NW-1:0] num0;
  logic [NW-1:0] den0;

  logic [NW-1:0] rem [QB+1];
  logic [NW-1:0] den [QB+1];
  logic [QB-1:0] qq  [QB+1];
  logic          ng  [QB+1];
  logic          bg  [QB+1];

  always_comb begin
    cm   = c[CW-1] ? CW'(-c) : CW'(c);
    dm   = det[DW-1] ? DW'(-det) : DW'(det);
    num0 = (NW'(cm) << NSH) + NW'(dm);   // 2n + d for round half away
    den0 = NW'(dm) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num0;
      den[0] <= den0;
      qq[0]  <= '0;
      ng[0]  <= c[CW-1] ^ det[DW-1];
      bg[0]  <= {{QB{1'b0}}, num0} >= {den0, {QB{1'b0}}};
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [NW+QB-1:0] ext;
    logic [NW+QB-1:0] ds;
    logic             hit;
    always_comb begin
      ext = {{QB{1'b0}}, rem[k]};
      ds  = {{QB{1'b0}}, den[k]} << SH;
      hit = ext >= ds;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= hit ? NW'(ext - ds) : rem[k];
        den[k+1] <= den[k];
        qq[k+1]  <= {qq[k][QB-2:0], hit};
        ng[k+1]  <= ng[k];
        bg[k+1]  <= bg[k];
      end
    end
  end

  assign quo = '{neg: ng[QB], big: bg[QB], q: qq[QB]};

endmodule

[rtl/m3i_merge.sv]
// ----------------------------------------------------------------------------
// m3i_merge
// saturates quotients, identity if singular, flags into output register
// ----------------------------------------------------------------------------
module m3i_merge import m3i_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  quo_t  quo [9],
  input  logic  sing_in,
  output elem_t r [9],
  output logic  singular,
  output logic  overflow
);

  localparam logic [QB-1:0] LIM_POS = QB'({1'b0, {(EW-1){1'b1}}});
  localparam logic [QB-1:0] LIM_NEG = QB'({1'b1, {(EW-1){1'b0}}});

  elem_t r_next [9];
  logic  ovf_next;

  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] mag;
    logic          sat;
    ovf_next = 1'b0;
    for (int k = 0; k < 9; k++) begin
      lim = quo[k].neg ? LIM_NEG : LIM_POS;
      sat = quo[k].big || (quo[k].q > lim);
      mag = sat ? lim : quo[k].q;
      r_next[k] = quo[k].neg ? elem_t'(-mag) : elem_t'(mag);
      ovf_next  = ovf_next | sat;
      if (sing_in) begin
        r_next[k] = (k % 4 == 0) ? ONE_VAL : '0;
      end
    end
    if (sing_in) begin
      ovf_next = ONE_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r        <= r_next;
      singular <= sing_in;
      overflow <= ovf_next;
    end
  end

endmodule

[rtl/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 signed fixed point matrix inverse through adjugate and determinant
// ----------------------------------------------------------------------------
// data passes the cofactor front end, the divider lanes, then the merge register
// one matrix per cycle while the output is not stalled, set by the nine bit-per-stage dividers
// the whole pipeline advances when the output register is empty or taken
// rst (synchronous, active high) clears the valid pipeline only
module matrix3_inverse import m3i_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
  output logic [1:0]        m_axis_tuser    // singular, overflow
);

  localparam int VL = FRONT_LAT + LANE_LAT;

  logic  en;
  elem_t a [9];
  cof_t  c [9];
  det_t  det;
  quo_t  quo [9];
  elem_t r [9];
  logic  singular;
  logic  overflow;
  logic  vld [VL];
  logic  sing [LANE_LAT];

  // pipeline moves whenever the output word can be replaced
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  for (genvar k = 0; k < 9; k++) begin : g_io
    assign a[k] = s_axis_tdata[k*EW +: EW];
    assign m_axis_tdata[k*EW +: EW] = r[k];
  end
  if (DATA_W > 9 * EW) begin : g_pad
    assign m_axis_tdata[DATA_W-1:9*EW] = '0;
  end
  assign m_axis_tuser = {overflow, singular};

  // valid tracking, one bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < VL; k++) vld[k] <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int k = 1; k < VL; k++) vld[k] <= vld[k-1];
      m_axis_tvalid <= vld[VL-1];
    end
  end

  // zero determinant travels beside the divider lanes
  always_ff @(posedge clk) begin
    if (en) begin
      sing[0] <= (det == '0);
      for (int k = 1; k < LANE_LAT; k++) sing[k] <= sing[k-1];
    end
  end

  m3i_cofactor u_cof (
    .clk (clk),
    .en  (en),
    .a   (a),
    .c   (c),
    .det (det)
  );

  // one divider lane per inverse element
  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3i_div_lane u_lane (
      .clk (clk),
      .en  (en),
      .c   (c[k]),
      .det (det),
      .quo (quo[k])
    );
  end

  m3i_merge u_merge (
    .clk      (clk),
    .en       (en),
    .quo      (quo),
    .sing_in  (sing[LANE_LAT-1]),
    .r        (r),
    .singular (singular),
    .overflow (overflow)
  );

endmodule

[rtl/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker
// port level checks for the matrix inverse, bound to the top level
// ----------------------------------------------------------------------------
module m3i_checker import m3i_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [DATA_W-1:0] m_axis_tdata,
  input logic [1:0]        m_axis_tuser
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // input side tracks output register occupancy
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  // singular result carries ONE_VAL in r00, zero in r01 and fixed overflow
  a_sing: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[EW-1:0] == ONE_VAL && m_axis_tdata[2*EW-1:EW] == '0
      && m_axis_tuser[1] == ONE_OVF)
    else $error("singular result is not identity");

  // no output without a pipeline of work behind it after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind matrix3_inverse m3i_checker u_chk (.*);
